// File: src/svpwm_pkg.sv
// Shared types, widths and constants for the SVPWM duty pipeline.
// Depends on nothing; every module of the block refers to it by scoped name.
package svpwm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // sqrt(3)/2 in Q29
  localparam int KW = 30;
  localparam logic signed [KW-1:0] SQRT3_HALF_Q29 = 30'sd464943848;

  // Phase voltages in units of 2^-(FRAC_BITS+30)
  localparam int VW        = SAMPLE_BITS + KW;
  localparam int DFW       = VW + 1;
  localparam int Q20_SHIFT = FRAC_BITS + 10;
  localparam int DW        = DFW - Q20_SHIFT;
  // (D + 24) >> 4, then divided by three
  localparam int XW          = DW - 3;
  localparam int RECIP_SHIFT = XW + 1;
  localparam logic [XW-1:0] RECIP_M =
    XW'(((longint'(1) << RECIP_SHIFT) + 2) / 3);
  localparam logic [DW:0] ROUND_BIAS = (DW+1)'(24);
  localparam int TW = XW - 1;
  // reciprocal products of the divide-by-three stage
  localparam int PW = 2 * XW;

  localparam int DUTY_W = 16;
  localparam logic [DUTY_W-1:0] ONE_Q15  = 16'd32768;
  localparam logic [DUTY_W-1:0] HALF_Q15 = 16'd16384;

  // Largest magnitude that still counts as a near-zero vector component
  localparam longint NZ_MAX = ((longint'(1) << FRAC_BITS) - 1) / 1000000;
  localparam logic signed [SAMPLE_BITS:0] NZ_LIM = (SAMPLE_BITS+1)'(NZ_MAX);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [VW-1:0]          vec_t;
  typedef logic [DUTY_W-1:0]             duty_t;
  typedef logic [XW-1:0]                 frac_t;
  typedef logic [PW-1:0]                 prod_t;

  typedef struct packed {
    logic nz;
    vec_t va;
    vec_t vb;
    vec_t vc;
  } proj_t;

  typedef struct packed {
    logic  nz;
    frac_t x_act;
    frac_t x_a;
    frac_t x_b;
    frac_t x_c;
  } span_t;

  typedef struct packed {
    duty_t duty_a;
    duty_t duty_b;
    duty_t duty_c;
  } duty_set_t;

  function automatic logic near_zero(input sample_t x);
    logic signed [SAMPLE_BITS:0] xe;
    xe = {x[SAMPLE_BITS-1], x};
    return (xe <= NZ_LIM) && (xe >= -NZ_LIM);
  endfunction

  function automatic duty_t sat_one(input logic [TW:0] x);
    return (x > (TW+1)'(ONE_Q15)) ? ONE_Q15 : x[DUTY_W-1:0];
  endfunction

endpackage

// File: src/svpwm_proj.sv
// Inverse Clarke projection: two register stages (beta scaling, phase sums).
// Depends on svpwm_pkg.
module svpwm_proj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  svpwm_pkg::sample_t  s_alpha,
  input  svpwm_pkg::sample_t  s_beta,
  output logic                m_valid,
  input  logic                m_ready,
  output svpwm_pkg::proj_t    m_data
);

  logic               s1_valid_r, s2_valid_r;
  logic               s1_ready, s2_ready;
  svpwm_pkg::sample_t a_r;
  svpwm_pkg::vec_t    bk_r, bk_nxt;
  logic               nz_r, nz_nxt;
  svpwm_pkg::proj_t   p_r, p_nxt;
  svpwm_pkg::vec_t    a29, a30;

  assign s2_ready = !s2_valid_r || m_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s_ready  = s1_ready;

  // scale beta by sqrt(3)/2
  assign bk_nxt = svpwm_pkg::vec_t'(s_beta) * svpwm_pkg::vec_t'(svpwm_pkg::SQRT3_HALF_Q29);
  assign nz_nxt = svpwm_pkg::near_zero(s_alpha) && svpwm_pkg::near_zero(s_beta);

  assign a30 = {a_r, 30'b0};
  assign a29 = {{(svpwm_pkg::VW - svpwm_pkg::SAMPLE_BITS - 29){a_r[svpwm_pkg::SAMPLE_BITS-1]}},
                a_r, 29'b0};

  always_comb begin
    p_nxt.nz = nz_r;
    p_nxt.va = a30;
    p_nxt.vb = bk_r - a29;
    p_nxt.vc = -bk_r - a29;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= s_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_valid) begin
      a_r  <= s_alpha;
      bk_r <= bk_nxt;
      nz_r <= nz_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      p_r <= p_nxt;
    end
  end

  assign m_valid = s2_valid_r;
  assign m_data  = p_r;

endmodule

// File: src/svpwm_span.sv
// Max/min search over the phase voltages and Q20 differences against the minimum.
// Depends on svpwm_pkg.
module svpwm_span (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  svpwm_pkg::proj_t  s_data,
  output logic              m_valid,
  input  logic              m_ready,
  output svpwm_pkg::span_t  m_data
);

  logic             s1_valid_r, s2_valid_r;
  logic             s1_ready, s2_ready;
  svpwm_pkg::proj_t p_r;
  svpwm_pkg::vec_t  vmax_r, vmin_r, vmax_nxt, vmin_nxt, ab_max, ab_min;
  svpwm_pkg::span_t x_r, x_nxt;

  assign s2_ready = !s2_valid_r || m_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s_ready  = s1_ready;

  assign ab_max   = (s_data.vb > s_data.va) ? s_data.vb : s_data.va;
  assign ab_min   = (s_data.vb < s_data.va) ? s_data.vb : s_data.va;
  assign vmax_nxt = (s_data.vc > ab_max) ? s_data.vc : ab_max;
  assign vmin_nxt = (s_data.vc < ab_min) ? s_data.vc : ab_min;

  // truncate the difference to Q20, add the rounding bias, drop four bits
  function automatic svpwm_pkg::frac_t span_of(input svpwm_pkg::vec_t v,
                                               input svpwm_pkg::vec_t vmin);
    logic [svpwm_pkg::DFW-1:0] diff;
    logic [svpwm_pkg::DW:0]    biased;
    diff   = $unsigned({v[svpwm_pkg::VW-1], v} - {vmin[svpwm_pkg::VW-1], vmin});
    biased = {1'b0, diff[svpwm_pkg::DFW-1:svpwm_pkg::Q20_SHIFT]} + svpwm_pkg::ROUND_BIAS;
    return biased[svpwm_pkg::DW:4];
  endfunction

  always_comb begin
    x_nxt.nz    = p_r.nz;
    x_nxt.x_act = span_of(vmax_r, vmin_r);
    x_nxt.x_a   = span_of(p_r.va, vmin_r);
    x_nxt.x_b   = span_of(p_r.vb, vmin_r);
    x_nxt.x_c   = span_of(p_r.vc, vmin_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= s_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_valid) begin
      p_r    <= s_data;
      vmax_r <= vmax_nxt;
      vmin_r <= vmin_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      x_r <= x_nxt;
    end
  end

  assign m_valid = s2_valid_r;
  assign m_data  = x_r;

endmodule

// File: src/svpwm_scale.sv
// Divide by three through a reciprocal multiply, then centre and saturate the duties.
// Depends on svpwm_pkg.
module svpwm_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  svpwm_pkg::span_t     s_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output svpwm_pkg::duty_set_t m_data
);

  logic                 s1_valid_r, s2_valid_r;
  logic                 s1_ready, s2_ready;
  logic                 nz_r;
  svpwm_pkg::prod_t     p_act_r, p_a_r, p_b_r, p_c_r;
  svpwm_pkg::prod_t     p_act_nxt, p_a_nxt, p_b_nxt, p_c_nxt;
  svpwm_pkg::duty_t     act, offset;
  svpwm_pkg::duty_set_t d_r, d_nxt;

  assign s2_ready = !s2_valid_r || m_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s_ready  = s1_ready;

  assign p_act_nxt = svpwm_pkg::prod_t'(s_data.x_act) * svpwm_pkg::prod_t'(svpwm_pkg::RECIP_M);
  assign p_a_nxt   = svpwm_pkg::prod_t'(s_data.x_a)   * svpwm_pkg::prod_t'(svpwm_pkg::RECIP_M);
  assign p_b_nxt   = svpwm_pkg::prod_t'(s_data.x_b)   * svpwm_pkg::prod_t'(svpwm_pkg::RECIP_M);
  assign p_c_nxt   = svpwm_pkg::prod_t'(s_data.x_c)   * svpwm_pkg::prod_t'(svpwm_pkg::RECIP_M);

  function automatic svpwm_pkg::duty_t duty_of(input svpwm_pkg::prod_t p,
                                               input svpwm_pkg::duty_t off);
    logic [svpwm_pkg::TW:0] sum;
    sum = (svpwm_pkg::TW+1)'(p[svpwm_pkg::PW-1:svpwm_pkg::RECIP_SHIFT])
        + (svpwm_pkg::TW+1)'(off);
    return svpwm_pkg::sat_one(sum);
  endfunction

  assign act    = svpwm_pkg::sat_one(
                    (svpwm_pkg::TW+1)'(p_act_r[svpwm_pkg::PW-1:svpwm_pkg::RECIP_SHIFT]));
  assign offset = (svpwm_pkg::ONE_Q15 - act) >> 1;

  always_comb begin
    if (nz_r) begin
      d_nxt.duty_a = svpwm_pkg::HALF_Q15;
      d_nxt.duty_b = svpwm_pkg::HALF_Q15;
      d_nxt.duty_c = svpwm_pkg::HALF_Q15;
    end else begin
      d_nxt.duty_a = duty_of(p_a_r, offset);
      d_nxt.duty_b = duty_of(p_b_r, offset);
      d_nxt.duty_c = duty_of(p_c_r, offset);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= s_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_valid) begin
      nz_r    <= s_data.nz;
      p_act_r <= p_act_nxt;
      p_a_r   <= p_a_nxt;
      p_b_r   <= p_b_nxt;
      p_c_r   <= p_c_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      d_r <= d_nxt;
    end
  end

  assign m_valid = s2_valid_r;
  assign m_data  = d_r;

endmodule

// File: src/svpwm_seven_segment_duty.sv
// Top level of the space-vector PWM duty generator (min/max injection).
// Depends on svpwm_pkg, svpwm_proj, svpwm_span and svpwm_scale.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one alpha/beta voltage pair in
//   signed Q1.15. Result channel (out_valid/out_ready) carries the three phase
//   duties in unsigned Q15, 32768 meaning 1.0, each in 0..32768.
//   One result transaction leaves for every input transaction, in order.
//
// Stages and throughput:
//   Six register stages: beta scaling, phase sums, max/min, Q20 differences,
//   reciprocal multiply by 1/3, centring and saturation. When nothing stalls,
//   a new transaction is taken every cycle. The depth is set by the sqrt(3)/2
//   multiplier and the divide-by-three multipliers, each with its own stage.
//
// Reset: rst_n is synchronous and active low; it empties every stage and
//   drops out_valid. Datapath registers are not reset.
// Stall: when out_ready is low the last stage holds its transaction, and each
//   earlier stage keeps accepting until the bubble ahead of it is filled; then
//   in_ready falls. Nothing is dropped or repeated.
module svpwm_seven_segment_duty (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  svpwm_pkg::sample_t  in_voltage_alpha,
  input  svpwm_pkg::sample_t  in_voltage_beta,
  output logic                out_valid,
  input  logic                out_ready,
  output svpwm_pkg::duty_t    out_phase_a_duty,
  output svpwm_pkg::duty_t    out_phase_b_duty,
  output svpwm_pkg::duty_t    out_phase_c_duty
);

  logic                 proj_valid, proj_ready;
  svpwm_pkg::proj_t     proj_data;
  logic                 span_valid, span_ready;
  svpwm_pkg::span_t     span_data;
  svpwm_pkg::duty_set_t duty_data;

  // Stages one and two: project alpha/beta onto the three phases
  svpwm_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_alpha (in_voltage_alpha),
    .s_beta  (in_voltage_beta),
    .m_valid (proj_valid),
    .m_ready (proj_ready),
    .m_data  (proj_data)
  );

  // Stages three and four: find the extremes, form the rounded differences
  svpwm_span u_span (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (proj_valid),
    .s_ready (proj_ready),
    .s_data  (proj_data),
    .m_valid (span_valid),
    .m_ready (span_ready),
    .m_data  (span_data)
  );

  // Stages five and six: take two thirds, add the centring offset, saturate
  svpwm_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (span_valid),
    .s_ready (span_ready),
    .s_data  (span_data),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (duty_data)
  );

  assign out_phase_a_duty = duty_data.duty_a;
  assign out_phase_b_duty = duty_data.duty_b;
  assign out_phase_c_duty = duty_data.duty_c;

endmodule

// File: src/svpwm_chk.sv
// Port-level checks for svpwm_seven_segment_duty, bound to the top level.
// Depends on svpwm_pkg and the top level's ports.
module svpwm_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input svpwm_pkg::duty_t out_phase_a_duty,
  input svpwm_pkg::duty_t out_phase_b_duty,
  input svpwm_pkg::duty_t out_phase_c_duty
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // duties never exceed one
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase_a_duty <= svpwm_pkg::ONE_Q15) &&
                  (out_phase_b_duty <= svpwm_pkg::ONE_Q15) &&
                  (out_phase_c_duty <= svpwm_pkg::ONE_Q15))
    else $error("duty above 1.0");

  // the lowest phase sits at the offset, which is at most one half
  a_min_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase_a_duty <= svpwm_pkg::HALF_Q15) ||
                  (out_phase_b_duty <= svpwm_pkg::HALF_Q15) ||
                  (out_phase_c_duty <= svpwm_pkg::HALF_Q15))
    else $error("no phase at or below one half");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind svpwm_seven_segment_duty svpwm_chk u_svpwm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_phase_a_duty (out_phase_a_duty),
  .out_phase_b_duty (out_phase_b_duty),
  .out_phase_c_duty (out_phase_c_duty)
);

// File: bench/svpwm_duty_checker.sv
// Checker for the SVPWM duty generator: watches both channels, predicts the
// three phase duties for every accepted voltage pair and compares them in order.
// Depends on svpwm_pkg for the sample and duty types.
module svpwm_duty_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  svpwm_pkg::sample_t  in_voltage_alpha,
  input  svpwm_pkg::sample_t  in_voltage_beta,
  input  logic                out_valid,
  input  logic                out_ready,
  input  svpwm_pkg::duty_t    out_phase_a_duty,
  input  svpwm_pkg::duty_t    out_phase_b_duty,
  input  svpwm_pkg::duty_t    out_phase_c_duty,
  output int                  mismatch_count,
  output int                  duties_outstanding
);

  import svpwm_pkg::*;

  localparam longint SQRT3_HALF_Q29 = 464943848;
  localparam int     TO_Q20_SHIFT   = SAMPLE_BITS - 1 + 10;
  localparam longint FULL_SCALE     = 32768;

  duty_set_t expected_duties[$];

  // 2/3 of a non-negative phase difference, in Q15, rounded half up
  function automatic longint two_thirds_of(input longint diff);
    longint d;
    d = diff >>> TO_Q20_SHIFT;
    return (2 * d + 48) / 96;
  endfunction

  function automatic longint clamp_full(input longint x);
    return (x > FULL_SCALE) ? FULL_SCALE : x;
  endfunction

  function automatic duty_set_t predict_duties(input sample_t alpha, input sample_t beta);
    longint a, b, mag_a, mag_b, vmax, vmin, active, offset;
    longint ph[3];
    longint duty[3];
    duty_set_t r;
    a = alpha;
    b = beta;
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    if (mag_a * 1000000 < (longint'(1) << (SAMPLE_BITS - 1)) &&
        mag_b * 1000000 < (longint'(1) << (SAMPLE_BITS - 1))) begin
      r.duty_a = duty_t'(FULL_SCALE / 2);
      r.duty_b = duty_t'(FULL_SCALE / 2);
      r.duty_c = duty_t'(FULL_SCALE / 2);
      return r;
    end
    ph[0] = a * (longint'(1) << 30);
    ph[1] = -(a * (longint'(1) << 29)) + b * SQRT3_HALF_Q29;
    ph[2] = -(a * (longint'(1) << 29)) - b * SQRT3_HALF_Q29;
    vmax = ph[0];
    vmin = ph[0];
    for (int i = 1; i < 3; i++) begin
      if (ph[i] > vmax) vmax = ph[i];
      if (ph[i] < vmin) vmin = ph[i];
    end
    active = clamp_full(two_thirds_of(vmax - vmin));
    offset = (FULL_SCALE - active) >>> 1;
    for (int i = 0; i < 3; i++)
      duty[i] = clamp_full(two_thirds_of(ph[i] - vmin) + offset);
    r.duty_a = duty_t'(duty[0]);
    r.duty_b = duty_t'(duty[1]);
    r.duty_c = duty_t'(duty[2]);
    return r;
  endfunction

  task automatic compare_phase(input string tag, input duty_t exp_v, input duty_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s duty mismatch, expected %0d actual %0d", $time, tag, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    duties_outstanding = 0;
  end

  // Push before pop so that a same-cycle result would still find its entry
  always @(posedge clk) begin
    duty_set_t exp_set;
    if (!rst_n) begin
      expected_duties.delete();
    end else begin
      if (in_valid && in_ready)
        expected_duties.push_back(predict_duties(in_voltage_alpha, in_voltage_beta));
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
                   out_phase_a_duty, out_phase_b_duty, out_phase_c_duty);
          mismatch_count++;
        end else begin
          exp_set = expected_duties.pop_front();
          compare_phase("phase A", exp_set.duty_a, out_phase_a_duty);
          compare_phase("phase B", exp_set.duty_b, out_phase_b_duty);
          compare_phase("phase C", exp_set.duty_c, out_phase_c_duty);
        end
      end
    end
    duties_outstanding = expected_duties.size();
  end

endmodule

// File: bench/svpwm_seven_segment_duty_tb.sv
// Testbench top for svpwm_seven_segment_duty: clock, reset, stimulus and verdict.
// Depends on svpwm_pkg, the block itself and svpwm_duty_checker for prediction.
module svpwm_seven_segment_duty_tb;

  import svpwm_pkg::*;

  // Cycles with no transaction on either side before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_VECTORS = 1500;
  localparam int QUIET_TAIL     = 200;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_voltage_alpha = '0;
  sample_t in_voltage_beta = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  duty_t   out_phase_a_duty;
  duty_t   out_phase_b_duty;
  duty_t   out_phase_c_duty;

  int      mismatch_count;
  int      duties_outstanding;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  logic    gaps_on = 1'b1;

  svpwm_seven_segment_duty u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_voltage_alpha (in_voltage_alpha),
    .in_voltage_beta  (in_voltage_beta),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_phase_a_duty (out_phase_a_duty),
    .out_phase_b_duty (out_phase_b_duty),
    .out_phase_c_duty (out_phase_c_duty)
  );

  svpwm_duty_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_voltage_alpha   (in_voltage_alpha),
    .in_voltage_beta    (in_voltage_beta),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_phase_a_duty   (out_phase_a_duty),
    .out_phase_b_duty   (out_phase_b_duty),
    .out_phase_c_duty   (out_phase_c_duty),
    .mismatch_count     (mismatch_count),
    .duties_outstanding (duties_outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver side: stall in random bursts while gaps are enabled,
  // otherwise hold ready high.
  always @(posedge clk) begin
    if (!gaps_on) begin
      hold_left <= 0;
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("svpwm_seven_segment_duty verification failed");
        $finish;
      end
    end
  end

  // Offer one voltage pair and return at the edge that accepts it. Ready is
  // looked at on the falling edge, where it has settled for the coming edge.
  task automatic offer_vector(input sample_t alpha, input sample_t beta);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_voltage_alpha <= alpha;
    in_voltage_beta  <= beta;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (duties_outstanding != 0);
    @(posedge clk);
  endtask

  function automatic sample_t rand_within(input int lim);
    int v;
    v = int'($urandom_range(0, 2 * lim)) - lim;
    return sample_t'(v);
  endfunction

  initial begin
    int pick;
    sample_t alpha, beta;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector (the near-zero case), unit steps, full-scale and
    // most negative corners (overmodulation) and a ring of sector vectors.
    offer_vector(16'sd0, 16'sd0);
    offer_vector(16'sd1, 16'sd0);
    offer_vector(-16'sd1, 16'sd0);
    offer_vector(16'sd0, 16'sd1);
    offer_vector(16'sd0, -16'sd1);
    offer_vector(-16'sd1, -16'sd1);
    offer_vector(16'sd32767, 16'sd0);
    offer_vector(-16'sd32768, 16'sd0);
    offer_vector(16'sd0, 16'sd32767);
    offer_vector(16'sd0, -16'sd32768);
    offer_vector(16'sd32767, 16'sd32767);
    offer_vector(-16'sd32768, -16'sd32768);
    offer_vector(16'sd32767, -16'sd32768);
    offer_vector(-16'sd32768, 16'sd32767);
    offer_vector(16'sd18900, 16'sd0);
    offer_vector(16'sd9450, 16'sd16368);
    offer_vector(-16'sd9450, 16'sd16368);
    offer_vector(-16'sd18900, 16'sd0);
    offer_vector(-16'sd9450, -16'sd16368);
    offer_vector(16'sd9450, -16'sd16368);
    offer_vector(16'sd16384, 16'sd16384);
    offer_vector(16'sd21845, -16'sd12);
    drain_results();

    // Random: full range for bit coverage, inside the linear region, tiny
    // magnitudes around the zero vector, and pinned extremes. Gaps come and go
    // in blocks of 100 and stop for the tail.
    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      if (n % 100 == 0)
        gaps_on <= (n < RANDOM_VECTORS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (n == RANDOM_VECTORS / 2)
        drain_results();
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        alpha = sample_t'($urandom);
        beta  = sample_t'($urandom);
      end else if (pick < 14) begin
        alpha = rand_within(18918);
        beta  = rand_within(18918);
      end else if (pick < 17) begin
        alpha = rand_within(64);
        beta  = rand_within(64);
      end else begin
        alpha = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        beta  = $urandom_range(0, 1) ? sample_t'($urandom) : 16'sh8000;
      end
      offer_vector(alpha, beta);
    end
    in_valid <= 1'b0;

    // Drain and let the pipeline settle before the verdict
    do @(negedge clk); while (duties_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && duties_outstanding == 0) begin
      $display("svpwm_seven_segment_duty verification clean");
    end else begin
      $display("svpwm_seven_segment_duty verification failed");
    end
    $finish;
  end

endmodule

// File: svpwm_seven_segment_duty.f
src/svpwm_pkg.sv
src/svpwm_proj.sv
src/svpwm_span.sv
src/svpwm_scale.sv
src/svpwm_seven_segment_duty.sv
src/svpwm_chk.sv
bench/svpwm_duty_checker.sv
bench/svpwm_seven_segment_duty_tb.sv
